>>> rtl/assert_macros.svh
// Assertion macros shared by the receiver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is high.
`define DFCR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define DFCR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/dfcr_pkg.sv
// Types and constants shared by the delimited frame receiver modules.
`timescale 1ns / 1ps
`default_nettype none
package dfcr_pkg;

   localparam int MAX_FRAME = 256;
   localparam int CNT_W     = $clog2(MAX_FRAME + 1);
   localparam int LEN_W     = 9;
   localparam int SUM_W     = 16;
   localparam int FCNT_W    = 32;

   localparam logic [7:0] OPEN_MARK  = 8'h40;
   localparam logic [7:0] CLOSE_MARK = 8'h23;
   localparam int         MIN_FRAME  = 6;
   localparam int         TAIL_HOLD  = 4;

   localparam logic [2:0] ST_GOOD     = 3'd0;
   localparam logic [2:0] ST_MISMATCH = 3'd1;
   localparam logic [2:0] ST_LOST     = 3'd2;
   localparam logic [2:0] ST_OVERFLOW = 3'd3;
   localparam logic [2:0] ST_SHORT    = 3'd4;

   // Event kinds handed from the front to the back.
   localparam logic [1:0] EV_DATA   = 2'd0;
   localparam logic [1:0] EV_OPEN   = 2'd1;
   localparam logic [1:0] EV_CLOSE  = 2'd2;
   localparam logic [1:0] EV_REPORT = 2'd3;

   typedef struct packed {
      logic [1:0]       kind;
      logic [7:0]       data;
      logic             sum_oldest;
      logic             lost;
      logic [2:0]       status;
      logic [LEN_W-1:0] len;
   } ev_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [LEN_W-1:0]  frame_length;
      logic [SUM_W-1:0]  computed_sum;
      logic [SUM_W-1:0]  received_sum;
      logic [FCNT_W-1:0] good_frames;
      logic [FCNT_W-1:0] dropped_frames;
   } rsp_type;

endpackage
`default_nettype wire

>>> rtl/dfcr_front.sv
// Front end: tracks framing of received bytes and classifies them into events.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module dfcr_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_push,
   output logic                 req_full,
   input  wire logic [7:0]      req_rx_byte,
   output logic                 ev_valid,
   output dfcr_pkg::ev_type     ev_data,
   input  wire logic            ev_ready
);
   import dfcr_pkg::*;

   logic             in_frame_ff, in_frame_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             accept;
   logic [CNT_W-1:0] count_plus;

   assign req_full   = !ev_ready;
   assign accept     = req_push && ev_ready;
   assign count_plus = count_ff + CNT_W'(1);

   always_comb begin
      in_frame_in = in_frame_ff;
      count_in    = count_ff;
      ev_valid    = 1'b0;
      ev_data     = '0;
      ev_data.data = req_rx_byte;
      if (accept) begin
         priority if (req_rx_byte == OPEN_MARK) begin
            ev_valid     = 1'b1;
            ev_data.kind = EV_OPEN;
            ev_data.lost = in_frame_ff;
            ev_data.len  = LEN_W'(count_ff);
            in_frame_in  = 1'b1;
            count_in     = CNT_W'(1);
         end else if (!in_frame_ff) begin
            // drop bytes outside a frame
         end else if (count_ff >= CNT_W'(MAX_FRAME)) begin
            ev_valid       = 1'b1;
            ev_data.kind   = EV_REPORT;
            ev_data.status = ST_OVERFLOW;
            ev_data.len    = LEN_W'(count_ff);
            in_frame_in    = 1'b0;
            count_in       = '0;
         end else if (req_rx_byte == CLOSE_MARK) begin
            ev_valid    = 1'b1;
            ev_data.len = LEN_W'(count_plus);
            if (count_plus < CNT_W'(MIN_FRAME)) begin
               ev_data.kind   = EV_REPORT;
               ev_data.status = ST_SHORT;
            end else begin
               ev_data.kind = EV_CLOSE;
            end
            in_frame_in = 1'b0;
            count_in    = '0;
         end else begin
            ev_valid           = 1'b1;
            ev_data.kind       = EV_DATA;
            ev_data.sum_oldest = (count_ff >= CNT_W'(TAIL_HOLD));
            count_in           = count_plus;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         count_ff    <= '0;
      end else begin
         in_frame_ff <= in_frame_in;
         count_ff    <= count_in;
      end
   end

   `DFCR_ASSERT(a_idle_count_zero, clock, reset, !in_frame_ff |-> (count_ff == '0),
      "byte count nonzero with no frame open")
   `DFCR_ASSERT(a_count_bounded, clock, reset,
      (accept && in_frame_ff && (count_ff >= CNT_W'(MAX_FRAME))) |=> !in_frame_ff ||
      (count_ff == CNT_W'(1)), "frame kept open past the maximum length")
endmodule
`default_nettype wire

>>> rtl/dfcr_evq.sv
// Two-entry event queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module dfcr_evq (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire dfcr_pkg::ev_type in_data,
   output logic                  in_ready,
   output logic                  out_valid,
   output dfcr_pkg::ev_type      out_data,
   input  wire logic             out_ready
);
   import dfcr_pkg::*;

   ev_type     entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   `DFCR_ASSERT(a_evq_ptrs, clock, reset,
      ((cnt_ff == 2'd1) == (wr_ptr_ff != rd_ptr_ff)) && (cnt_ff != 2'd3),
      "event queue pointers disagree with fill count")
endmodule
`default_nettype wire

>>> rtl/dfcr_back.sv
// Back end: tail window, pair checksum, counters and the result buffer.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module dfcr_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             ev_valid,
   input  wire dfcr_pkg::ev_type ev_data,
   output logic                  ev_ready,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output dfcr_pkg::rsp_type     rsp_data
);
   import dfcr_pkg::*;

   function automatic logic [SUM_W-1:0] fold_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
      logic [SUM_W:0] t;
      t = {1'b0, a} + {1'b0, b};
      return t[SUM_W-1:0] + SUM_W'(t[SUM_W]);
   endfunction

   // Uppercase hex digit: bit 4 flags a valid digit.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
      else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
      return r;
   endfunction

   logic [7:0]        win_ff [TAIL_HOLD];
   logic [7:0]        win_in [TAIL_HOLD];
   logic [SUM_W-1:0]  run_ff, run_in;
   logic [7:0]        hi_ff, hi_in;
   logic              pend_ff, pend_in;
   logic [FCNT_W-1:0] good_ff, good_in;
   logic [FCNT_W-1:0] drop_ff, drop_in;

   rsp_type    ob_ff [2];
   logic       ob_wr_ff, ob_rd_ff;
   logic [1:0] ob_cnt_ff;
   logic       ob_push, ob_pop;
   rsp_type    res;

   logic             needs_result, consume;
   logic [SUM_W-1:0] csum, rsum;
   logic [4:0]       dig [TAIL_HOLD];
   logic             hex_ok;

   assign needs_result = (ev_data.kind != EV_DATA) &&
                         !((ev_data.kind == EV_OPEN) && !ev_data.lost);
   assign ev_ready     = !needs_result || (ob_cnt_ff != 2'd2);
   assign consume      = ev_valid && ev_ready;
   assign ob_push      = consume && needs_result;
   assign ob_pop       = rsp_pop && !rsp_empty;
   assign rsp_empty    = (ob_cnt_ff == 2'd0);
   assign rsp_data     = ob_ff[ob_rd_ff];

   always_comb begin
      hex_ok = 1'b1;
      for (int i = 0; i < TAIL_HOLD; i++) begin
         dig[i] = hex_digit(win_ff[i]);
         hex_ok = hex_ok && dig[i][4];
      end
      rsum = hex_ok ? {dig[0][3:0], dig[1][3:0], dig[2][3:0], dig[3][3:0]} : '0;
      csum = pend_ff ? fold_add(run_ff, {hi_ff, 8'h00}) : run_ff;
   end

   always_comb begin
      win_in  = win_ff;
      run_in  = run_ff;
      hi_in   = hi_ff;
      pend_in = pend_ff;
      good_in = good_ff;
      drop_in = drop_ff;
      res     = '0;
      res.frame_length = ev_data.len;
      if (consume) begin
         unique case (ev_data.kind)
            EV_DATA: begin
               if (ev_data.sum_oldest) begin
                  if (pend_ff) begin
                     run_in  = fold_add(run_ff, {hi_ff, win_ff[0]});
                     pend_in = 1'b0;
                     hi_in   = '0;
                  end else begin
                     hi_in   = win_ff[0];
                     pend_in = 1'b1;
                  end
               end
               for (int i = 0; i < TAIL_HOLD - 1; i++) win_in[i] = win_ff[i+1];
               win_in[TAIL_HOLD-1] = ev_data.data;
            end
            EV_OPEN: begin
               res.status = ST_LOST;
            end
            EV_REPORT: begin
               res.status = ev_data.status;
            end
            EV_CLOSE: begin
               res.status       = (csum == rsum) ? ST_GOOD : ST_MISMATCH;
               res.computed_sum = csum;
               res.received_sum = rsum;
            end
            default: begin
            end
         endcase
         if (ev_data.kind != EV_DATA) begin
            // clear the frame state; an open starts over with its marker
            for (int i = 0; i < TAIL_HOLD; i++) win_in[i] = '0;
            if (ev_data.kind == EV_OPEN) win_in[TAIL_HOLD-1] = OPEN_MARK;
            run_in  = '0;
            hi_in   = '0;
            pend_in = 1'b0;
         end
         if (needs_result) begin
            if (res.status == ST_GOOD) good_in = good_ff + FCNT_W'(1);
            else                       drop_in = drop_ff + FCNT_W'(1);
         end
      end
      res.good_frames    = good_in;
      res.dropped_frames = drop_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TAIL_HOLD; i++) win_ff[i] <= '0;
         run_ff  <= '0;
         hi_ff   <= '0;
         pend_ff <= 1'b0;
         good_ff <= '0;
         drop_ff <= '0;
      end else begin
         win_ff  <= win_in;
         run_ff  <= run_in;
         hi_ff   <= hi_in;
         pend_ff <= pend_in;
         good_ff <= good_in;
         drop_ff <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ob_push) begin
         ob_ff[ob_wr_ff] <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ob_wr_ff  <= 1'b0;
         ob_rd_ff  <= 1'b0;
         ob_cnt_ff <= 2'd0;
      end else begin
         if (ob_push) ob_wr_ff <= !ob_wr_ff;
         if (ob_pop)  ob_rd_ff <= !ob_rd_ff;
         ob_cnt_ff <= ob_cnt_ff + {1'b0, ob_push} - {1'b0, ob_pop};
      end
   end

   `DFCR_ASSERT(a_good_counts, clock, reset, (ob_push && (res.status == ST_GOOD)) |=>
      (good_ff == $past(good_ff) + FCNT_W'(1)) && $stable(drop_ff),
      "good frame not counted exactly once")
   `DFCR_ASSERT(a_good_sums, clock, reset,
      (ob_push && (res.status == ST_GOOD)) |-> (res.computed_sum == res.received_sum),
      "good status with differing checksums")
   `DFCR_ASSERT_ALWAYS(a_ob_bound, clock, reset || (ob_cnt_ff != 2'd3),
      "result buffer overfilled")
endmodule
`default_nettype wire

>>> rtl/delimited_frame_checksum_receiver_core.sv
// Top level of the delimited frame checksum receiver.
`timescale 1ns / 1ps
`default_nettype none
// Frame receiver for '@' ... '#' delimited character frames. Push one received
// byte per transaction on the req_ side; the block accepts one byte every clock
// cycle, and a byte waits (req_full high) only when the two-entry event queue
// is full, which happens when the two-entry result buffer fills because results
// are not being popped. A result reaches the rsp_ side by way of the event queue
// entry and then the checksum stage into the result buffer, both registered. One
// result per frame end or drop: status, length, the
// 16-bit end-around-carry sum of big-endian byte pairs over the frame without
// its four trailing hex digits and the closing mark, the value of those
// digits, and running good and drop counts. Bytes outside a frame produce no
// result and are consumed at once.
module delimited_frame_checksum_receiver_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [2:0]       rsp_status,
   output logic [8:0]       rsp_frame_length,
   output logic [15:0]      rsp_computed_sum,
   output logic [15:0]      rsp_received_sum,
   output logic [31:0]      rsp_good_frames,
   output logic [31:0]      rsp_dropped_frames
);
   import dfcr_pkg::*;

   // front end to queue
   logic    fe_valid, fe_ready;
   ev_type  fe_data;
   // queue to back end
   logic    be_valid, be_ready;
   ev_type  be_data;
   rsp_type rsp_data;

   // Classify each byte against the framing state; ignored bytes go nowhere.
   dfcr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_rx_byte (req_rx_byte),
      .ev_valid    (fe_valid),
      .ev_data     (fe_data),
      .ev_ready    (fe_ready)
   );

   // Decouple classification from checksum work so each side can stall.
   dfcr_evq u_evq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fe_valid),
      .in_data   (fe_data),
      .in_ready  (fe_ready),
      .out_valid (be_valid),
      .out_data  (be_data),
      .out_ready (be_ready)
   );

   // Advance the tail window and pair sum, and report at frame end or drop.
   dfcr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .ev_valid  (be_valid),
      .ev_data   (be_data),
      .ev_ready  (be_ready),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   assign rsp_status         = rsp_data.status;
   assign rsp_frame_length   = rsp_data.frame_length;
   assign rsp_computed_sum   = rsp_data.computed_sum;
   assign rsp_received_sum   = rsp_data.received_sum;
   assign rsp_good_frames    = rsp_data.good_frames;
   assign rsp_dropped_frames = rsp_data.dropped_frames;
endmodule
`default_nettype wire
